// ----- rtl/dtt_pkg.sv -----
// Package with types, constants and helpers shared by the transaction tracker table.
`timescale 1ns / 1ps
package dtt_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam logic [31:0] TtlReset = 32'd60;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_MATCH  = 3'd1,
    CMD_EXPIRE = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_RESET  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WAIT,
    ST_CHECK,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] txid;
    logic [15:0] qtype;
    logic [31:0] src_addr;
    logic [31:0] answer_addr;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [15:0] entry_qtype;
    logic [31:0] entry_src;
    logic [31:0] entry_time;
    logic        entry_answered;
    logic [31:0] entry_resolved;
    logic [6:0]  active_count;
    logic [31:0] queries_total;
    logic [31:0] responses_total;
    logic [31:0] expired_total;
  } out_word_t;

  // One stored table entry.
  typedef struct packed {
    logic [15:0] txid;
    logic [15:0] qtype;
    logic [31:0] src;
    logic [31:0] stamp;
    logic        answered;
    logic [31:0] resolved;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ----- rtl/dtt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module dtt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/dns_transaction_tracker_table.sv -----
// Top level of the DNS transaction tracker table: sequencer, counters and entry RAM.
//
//  channel | signals                    | direction | payload
//  in      | in_valid / in_ready        | input     | dtt_pkg::in_word_t
//  out     | out_valid / out_ready      | output    | dtt_pkg::out_word_t
//  cfg     | cfg_valid / cfg_ready      | input     | entry lifetime, 32 bits
//
// Add, reset and unknown codes skip to the done state, which raises out_valid.
// Match and lookup pass each scanned entry through read, wait and check, expire
// adds a move per removal, paced by the single registered RAM read port.
// Reset is synchronous; the table needs no clearing pass since only entries
// below the fill count are read. in_ready is low from accept until the result
// is taken; a stalled result is held in the output register.
`timescale 1ns / 1ps
module dns_transaction_tracker_table #(
  parameter int unsigned TableDepth = dtt_pkg::TableDepthDefault,
  localparam int unsigned AW = $clog2(TableDepth),
  localparam int unsigned CW = $clog2(TableDepth + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dtt_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dtt_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_lifetime
);

  dtt_pkg::state_t   state_r, state_nxt;
  dtt_pkg::in_word_t req_r, req_nxt;
  dtt_pkg::out_word_t res_r, res_nxt;
  dtt_pkg::entry_t   rdata, wdata;
  logic [31:0] ttl_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [31:0] qcnt_r, qcnt_nxt, rcnt_r, rcnt_nxt, ecnt_r, ecnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] age;

  assign in_ready  = (state_r == dtt_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;
  assign age = req_r.now_seconds - rdata.stamp;

  dtt_ram #(.Width(dtt_pkg::EntryW), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtt_pkg::ST_IDLE;
      used_r <= '0;
      qcnt_r <= '0;
      rcnt_r <= '0;
      ecnt_r <= '0;
      out_valid_r <= 1'b0;
      ttl_r <= dtt_pkg::TtlReset;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      qcnt_r <= qcnt_nxt;
      rcnt_r <= rcnt_nxt;
      ecnt_r <= ecnt_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r <= idx_nxt;
      if (cfg_valid) begin
        ttl_r <= cfg_lifetime;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    res_nxt = res_r;
    used_nxt = used_r;
    idx_nxt = idx_r;
    qcnt_nxt = qcnt_r;
    rcnt_nxt = rcnt_r;
    ecnt_nxt = ecnt_r;
    out_valid_nxt = out_valid_r;
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    raddr = idx_r[AW-1:0];
    wdata = rdata;
    unique case (state_r)
      dtt_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          idx_nxt = '0;
          state_nxt = dtt_pkg::ST_RD;
          res_nxt = '0;
          res_nxt.status = 1'b1;
          priority case (in_data.cmd)
            dtt_pkg::CMD_ADD: begin
              if (used_r < CW'(TableDepth)) begin
                we = 1'b1;
                waddr = used_r[AW-1:0];
                wdata = '{txid: in_data.txid, qtype: in_data.qtype,
                          src: in_data.src_addr, stamp: in_data.now_seconds,
                          answered: 1'b0, resolved: 32'd0};
                used_nxt = used_r + CW'(1);
                qcnt_nxt = dtt_pkg::sat_inc(qcnt_r);
                res_nxt.status = 1'b0;
              end
              state_nxt = dtt_pkg::ST_DONE;
            end
            dtt_pkg::CMD_RESET: begin
              used_nxt = '0;
              qcnt_nxt = '0;
              rcnt_nxt = '0;
              ecnt_nxt = '0;
              res_nxt.status = 1'b0;
              state_nxt = dtt_pkg::ST_DONE;
            end
            dtt_pkg::CMD_EXPIRE: begin
              res_nxt.status = 1'b0;
            end
            dtt_pkg::CMD_MATCH, dtt_pkg::CMD_LOOKUP: ;
            default: state_nxt = dtt_pkg::ST_DONE;
          endcase
        end
      end
      dtt_pkg::ST_RD: begin
        // Address presented here; data is registered for the next state.
        if (idx_r >= used_r) begin
          state_nxt = dtt_pkg::ST_DONE;
        end else begin
          state_nxt = dtt_pkg::ST_WAIT;
        end
      end
      dtt_pkg::ST_WAIT: begin
        state_nxt = dtt_pkg::ST_CHECK;
      end
      dtt_pkg::ST_CHECK: begin
        state_nxt = dtt_pkg::ST_RD;
        priority case (req_r.cmd)
          dtt_pkg::CMD_MATCH: begin
            if (rdata.txid == req_r.txid && !rdata.answered) begin
              we = 1'b1;
              wdata.answered = 1'b1;
              wdata.resolved = req_r.answer_addr;
              rcnt_nxt = dtt_pkg::sat_inc(rcnt_r);
              res_nxt.status = 1'b0;
              state_nxt = dtt_pkg::ST_DONE;
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
          dtt_pkg::CMD_LOOKUP: begin
            if (rdata.txid == req_r.txid) begin
              res_nxt.status = 1'b0;
              res_nxt.entry_qtype = rdata.qtype;
              res_nxt.entry_src = rdata.src;
              res_nxt.entry_time = rdata.stamp;
              res_nxt.entry_answered = rdata.answered;
              res_nxt.entry_resolved = rdata.resolved;
              state_nxt = dtt_pkg::ST_DONE;
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
          default: begin
            if (age > ttl_r) begin
              // Remove: fetch the last entry to move into this slot.
              ecnt_nxt = dtt_pkg::sat_inc(ecnt_r);
              used_nxt = used_r - CW'(1);
              state_nxt = dtt_pkg::ST_MOVE;
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
        endcase
        raddr = used_nxt[AW-1:0];
      end
      dtt_pkg::ST_MOVE: begin
        // rdata now holds the last entry; write it into the freed slot.
        we = 1'b1;
        wdata = rdata;
        state_nxt = dtt_pkg::ST_RD;
      end
      dtt_pkg::ST_DONE: begin
        if (!out_valid_r) begin
          res_nxt.active_count = 7'(used_r);
          res_nxt.queries_total = qcnt_r;
          res_nxt.responses_total = rcnt_r;
          res_nxt.expired_total = ecnt_r;
          out_valid_nxt = 1'b1;
        end else if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt = dtt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dtt_pkg::ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n) used_r <= CW'(TableDepth))
    else $error("fill count beyond table depth");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |-> state_r == dtt_pkg::ST_DONE)
    else $error("result shown outside done state");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dtt_pkg::ST_MOVE |=> $past(used_r) < $past(used_r, 2))
    else $error("move without removal");
  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid_r)
    else $error("ready while a result is pending");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the DNS transaction tracker table.
`timescale 1ns / 1ps

class tracker_scoreboard;
  logic [15:0] s_txid [64];
  logic [15:0] s_qtype [64];
  logic [31:0] s_src [64];
  logic [31:0] s_time [64];
  logic        s_ans [64];
  logic [31:0] s_res [64];
  int unsigned fill;
  logic [31:0] n_query, n_resp, n_expired, ttl;
  dtt_pkg::out_word_t pending [$];
  int          errors;

  function new();
    ttl = dtt_pkg::TtlReset;
    clear_table();
  endfunction

  function void clear_table();
    fill = 0;
    n_query = 0;
    n_resp = 0;
    n_expired = 0;
  endfunction

  function logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Applies one accepted command to the table copy and queues its result.
  function void note_command(dtt_pkg::in_word_t w);
    dtt_pkg::out_word_t r;
    int unsigned i;
    r = '0;
    r.status = 1'b1;
    case (w.cmd)
      dtt_pkg::CMD_ADD: begin
        if (fill < 64) begin
          s_txid[fill] = w.txid;
          s_qtype[fill] = w.qtype;
          s_src[fill] = w.src_addr;
          s_time[fill] = w.now_seconds;
          s_ans[fill] = 1'b0;
          s_res[fill] = '0;
          fill++;
          n_query = bump(n_query);
          r.status = 1'b0;
        end
      end
      dtt_pkg::CMD_MATCH: begin
        for (i = 0; i < fill; i++) begin
          if (s_txid[i] == w.txid && !s_ans[i]) begin
            s_ans[i] = 1'b1;
            s_res[i] = w.answer_addr;
            n_resp = bump(n_resp);
            r.status = 1'b0;
            break;
          end
        end
      end
      dtt_pkg::CMD_EXPIRE: begin
        i = 0;
        while (i < fill) begin
          if (32'(w.now_seconds - s_time[i]) > ttl) begin
            n_expired = bump(n_expired);
            fill--;
            s_txid[i] = s_txid[fill];
            s_qtype[i] = s_qtype[fill];
            s_src[i] = s_src[fill];
            s_time[i] = s_time[fill];
            s_ans[i] = s_ans[fill];
            s_res[i] = s_res[fill];
          end else begin
            i++;
          end
        end
        r.status = 1'b0;
      end
      dtt_pkg::CMD_LOOKUP: begin
        for (i = 0; i < fill; i++) begin
          if (s_txid[i] == w.txid) begin
            r.entry_qtype = s_qtype[i];
            r.entry_src = s_src[i];
            r.entry_time = s_time[i];
            r.entry_answered = s_ans[i];
            r.entry_resolved = s_res[i];
            r.status = 1'b0;
            break;
          end
        end
      end
      dtt_pkg::CMD_RESET: begin
        clear_table();
        r.status = 1'b0;
      end
      default: ;
    endcase
    r.active_count = 7'(fill);
    r.queries_total = n_query;
    r.responses_total = n_resp;
    r.expired_total = n_expired;
    pending.push_back(r);
  endfunction

  function void check_result(dtt_pkg::out_word_t got);
    dtt_pkg::out_word_t e;
    if (pending.size() == 0) begin
      $error("unexpected result word %h", got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.status !== e.status) begin
      $error("status exp %h got %h", e.status, got.status); errors++;
    end
    if (got.entry_qtype !== e.entry_qtype) begin
      $error("entry_qtype exp %h got %h", e.entry_qtype, got.entry_qtype); errors++;
    end
    if (got.entry_src !== e.entry_src) begin
      $error("entry_src exp %h got %h", e.entry_src, got.entry_src); errors++;
    end
    if (got.entry_time !== e.entry_time) begin
      $error("entry_time exp %h got %h", e.entry_time, got.entry_time); errors++;
    end
    if (got.entry_answered !== e.entry_answered) begin
      $error("entry_answered exp %h got %h", e.entry_answered, got.entry_answered);
      errors++;
    end
    if (got.entry_resolved !== e.entry_resolved) begin
      $error("entry_resolved exp %h got %h", e.entry_resolved, got.entry_resolved);
      errors++;
    end
    if (got.active_count !== e.active_count) begin
      $error("active_count exp %0d got %0d", e.active_count, got.active_count); errors++;
    end
    if (got.queries_total !== e.queries_total) begin
      $error("queries_total exp %0d got %0d", e.queries_total, got.queries_total);
      errors++;
    end
    if (got.responses_total !== e.responses_total) begin
      $error("responses_total exp %0d got %0d", e.responses_total, got.responses_total);
      errors++;
    end
    if (got.expired_total !== e.expired_total) begin
      $error("expired_total exp %0d got %0d", e.expired_total, got.expired_total);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  dtt_pkg::in_word_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  dtt_pkg::out_word_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [31:0] cfg_lifetime = '0;

  tracker_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;
  logic [31:0] clock_now = 32'd1000;
  logic [15:0] id_pool [8];

  dns_transaction_tracker_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_lifetime(cfg_lifetime)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 5000000) begin
      $display("[dns_transaction_tracker_table] ERROR");
      $finish;
    end
  end

  // Result side: check each taken word, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Valid stays high after an accept until the sender idles or drains.
  task automatic send_word(dtt_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ttl(logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_lifetime <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.ttl = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic dtt_pkg::in_word_t make_cmd(dtt_pkg::cmd_t c, logic [15:0] id);
    dtt_pkg::in_word_t w;
    w.cmd = c;
    w.txid = id;
    w.qtype = 16'($urandom);
    w.src_addr = $urandom;
    w.answer_addr = $urandom;
    w.now_seconds = clock_now;
    return w;
  endfunction

  // Mostly well-formed traffic on a small id pool with a slowly moving clock.
  function automatic dtt_pkg::in_word_t random_cmd();
    dtt_pkg::in_word_t w;
    int r;
    r = $urandom_range(99);
    clock_now = clock_now + $urandom_range(3);
    if (r < 35) w = make_cmd(dtt_pkg::CMD_ADD, id_pool[$urandom_range(7)]);
    else if (r < 60) w = make_cmd(dtt_pkg::CMD_MATCH, id_pool[$urandom_range(7)]);
    else if (r < 80) w = make_cmd(dtt_pkg::CMD_LOOKUP, id_pool[$urandom_range(7)]);
    else if (r < 90) w = make_cmd(dtt_pkg::CMD_EXPIRE, 16'($urandom));
    else if (r < 92) w = make_cmd(dtt_pkg::CMD_RESET, 16'($urandom));
    else if (r < 95) begin
      w = make_cmd(dtt_pkg::CMD_ADD, 16'($urandom));
      w.cmd = 3'($urandom_range(5, 7));
    end else begin
      w = make_cmd(dtt_pkg::cmd_t'($urandom_range(3)), 16'($urandom));
      w.now_seconds = $urandom;
    end
    return w;
  endfunction

  initial begin
    dtt_pkg::in_word_t w;
    int k;
    for (k = 0; k < 8; k++) id_pool[k] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, not-found cases, full table, time wrap, bad codes.
    send_word(make_cmd(dtt_pkg::CMD_MATCH, 16'h1234));
    send_word(make_cmd(dtt_pkg::CMD_LOOKUP, 16'h1234));
    w = make_cmd(dtt_pkg::CMD_ADD, 16'hFFFF);
    w.qtype = 16'hFFFF; w.src_addr = '1; w.now_seconds = '1;
    send_word(w);
    w = make_cmd(dtt_pkg::CMD_ADD, 16'h0000);
    w.qtype = '0; w.src_addr = '0; w.now_seconds = '0;
    send_word(w);
    w = make_cmd(dtt_pkg::CMD_MATCH, 16'hFFFF); w.answer_addr = '1; send_word(w);
    send_word(make_cmd(dtt_pkg::CMD_MATCH, 16'hFFFF));
    send_word(make_cmd(dtt_pkg::CMD_LOOKUP, 16'hFFFF));
    w = make_cmd(dtt_pkg::CMD_MATCH, 16'h0000); w.answer_addr = '0; send_word(w);
    send_word(make_cmd(dtt_pkg::CMD_LOOKUP, 16'h0000));
    w = make_cmd(dtt_pkg::CMD_EXPIRE, 16'h0); w.now_seconds = 32'd59; send_word(w);
    w = make_cmd(dtt_pkg::CMD_EXPIRE, 16'h0); w.now_seconds = 32'd61; send_word(w);
    w = make_cmd(dtt_pkg::CMD_ADD, 16'h0); w.cmd = 3'd5; send_word(w);
    w.cmd = 3'd6; send_word(w);
    w.cmd = 3'd7; send_word(w);
    for (k = 0; k < 66; k++) send_word(make_cmd(dtt_pkg::CMD_ADD, 16'(k)));
    send_word(make_cmd(dtt_pkg::CMD_LOOKUP, 16'd63));
    send_word(make_cmd(dtt_pkg::CMD_RESET, 16'h0));

    write_ttl(32'd0);
    for (k = 0; k < 4; k++) send_word(make_cmd(dtt_pkg::CMD_ADD, 16'(k)));
    clock_now++;
    send_word(make_cmd(dtt_pkg::CMD_EXPIRE, 16'h0));
    write_ttl(32'hFFFF_FFFF);
    send_word(make_cmd(dtt_pkg::CMD_ADD, 16'h5));
    w = make_cmd(dtt_pkg::CMD_EXPIRE, 16'h0); w.now_seconds = clock_now - 1; send_word(w);

    // Random phases at several ttl settings and idle mixes.
    for (k = 0; k < 8; k++) begin
      case (k % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 53; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 53; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      case (k)
        0: write_ttl(32'd60);
        1: write_ttl(32'd1);
        2: write_ttl(32'd20);
        3: write_ttl(32'd0);
        4: write_ttl(32'hFFFF_FFFF);
        default: write_ttl($urandom_range(5, 100));
      endcase
      repeat (200) begin
        send_word(random_cmd());
        // The sender occasionally waits for the block to empty out.
        if ($urandom_range(99) == 0) drain();
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[dns_transaction_tracker_table] OK");
    end else begin
      $display("[dns_transaction_tracker_table] ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/dtt_pkg.sv
rtl/dtt_ram.sv
rtl/dns_transaction_tracker_table.sv
test/tb_top.sv
